// ----- rtl/tljs_pkg.sv -----
package tljs_pkg;

	localparam int CW = 16;
	localparam int LW = 10;
	localparam int FB = 16;
	localparam logic [LW-1:0] LEN_RESET = LW'(50);

	localparam int AW = 16;
	localparam int D2W = 22;
	localparam int DXW = 11;
	localparam int NW = 23;
	localparam int SQ_RW = 54;
	localparam int SQ_QW = 27;
	localparam int DV_NW = 56;
	localparam int DV_DW = 28;
	localparam int DV_QW = 28;
	localparam int PW = 39;
	localparam int SW = 34;
	localparam int IW = SW - FB;

	localparam int SQA = SQ_QW;
	localparam int DVA = SQA + DV_QW;
	localparam int HRD = DVA + 2;
	localparam int SQH = HRD + SQ_QW;
	localparam int DVO = SQH + 1 + DV_QW;
	localparam int PTS = DVO + 2;
	localparam int SIDE_N = PTS + 1;
	localparam int LATENCY = 3 + PTS + 1;

	typedef enum logic [1:0] {
		PICK_MINX_MINY = 2'd0,
		PICK_MINY_MAXX = 2'd1,
		PICK_MINX_MAXY = 2'd2,
		PICK_MAXX_MAXY = 2'd3
	} pick_rule_t;

	typedef enum logic [0:0] {
		CFG_FIRST_LEN  = 1'b0,
		CFG_SECOND_LEN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] first_center_x;
		logic signed [CW-1:0] first_center_y;
		logic signed [CW-1:0] second_center_x;
		logic signed [CW-1:0] second_center_y;
		pick_rule_t           pick_rule;
	} in_t;

	typedef struct packed {
		logic                 found;
		logic signed [CW-1:0] first_point_x;
		logic signed [CW-1:0] first_point_y;
		logic signed [CW-1:0] second_point_x;
		logic signed [CW-1:0] second_point_y;
		logic signed [CW-1:0] chosen_x;
		logic signed [CW-1:0] chosen_y;
	} out_t;

	typedef struct packed {
		logic              found;
		logic [CW-1:0]     c0x;
		logic [CW-1:0]     c0y;
		logic [DXW-1:0]    dxa;
		logic [DXW-1:0]    dya;
		logic              dxs;
		logic              dys;
		pick_rule_t        rule;
		logic              nneg;
		logic [NW-1:0]     nabs;
		logic [2*LW-1:0]   r0sq;
		logic [SQ_QW-1:0]  dq;
		logic [DV_QW-1:0]  amag;
	} side_t;

	// truncate a fixed point value toward zero to its integer part
	function automatic logic [IW-1:0] trunc_int(input logic [SW-1:0] s);
		logic [SW-1:0] mag;
		logic [IW-1:0] q;
		mag = s[SW-1] ? (~s + SW'(1)) : s;
		q = mag[SW-1:FB];
		return s[SW-1] ? (~q + IW'(1)) : q;
	endfunction

endpackage

// ----- rtl/tljs_sqrt.sv -----
module tljs_sqrt (
	input  logic                         clk,
	input  logic [tljs_pkg::SQ_RW-1:0]   rad,
	output logic [tljs_pkg::SQ_QW-1:0]   root
);

	localparam int RW = tljs_pkg::SQ_RW;
	localparam int QW = tljs_pkg::SQ_QW;

	logic [RW-1:0] rem_s  [1:QW-1];
	logic [QW-1:0] root_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [RW-1:0] cur_rem;
		logic [QW-1:0] cur_root;
		logic [RW:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign cur_rem  = rad;
			assign cur_root = '0;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
		end

		// (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
		assign trial = ((RW+1)'(cur_root) << (B + 1)) + ((RW+1)'(1) << (2 * B));
		assign take  = {1'b0, cur_rem} >= trial;

		always_ff @(posedge clk) begin
			root_s[k+1] <= take ? (cur_root | (QW'(1) << B)) : cur_root;
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k+1] <= take ? RW'({1'b0, cur_rem} - trial) : cur_rem;
			end
		end
	end

	assign root = root_s[QW];

endmodule

// ----- rtl/tljs_div.sv -----
module tljs_div (
	input  logic                         clk,
	input  logic [tljs_pkg::DV_NW-1:0]   dividend,
	input  logic [tljs_pkg::DV_DW-1:0]   divisor,
	output logic [tljs_pkg::DV_QW-1:0]   quotient
);

	localparam int NW = tljs_pkg::DV_NW;
	localparam int DW = tljs_pkg::DV_DW;
	localparam int QW = tljs_pkg::DV_QW;

	logic [DW-1:0] rem_s [1:QW-1];
	logic [DW-1:0] dvs_s [1:QW-1];
	logic [QW-1:0] low_s [1:QW-1];
	logic [QW-1:0] quo_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] cur_rem;
		logic [DW-1:0] cur_dvs;
		logic [QW-1:0] cur_low;
		logic [QW-1:0] cur_quo;
		logic [DW:0]   part;
		logic          take;

		if (k == 0) begin : g_first
			assign cur_rem = dividend[NW-1:QW];
			assign cur_dvs = divisor;
			assign cur_low = dividend[QW-1:0];
			assign cur_quo = '0;
		end else begin : g_next
			assign cur_rem = rem_s[k];
			assign cur_dvs = dvs_s[k];
			assign cur_low = low_s[k];
			assign cur_quo = quo_s[k];
		end

		assign part = {cur_rem, cur_low[QW-1]};
		assign take = part >= {1'b0, cur_dvs};

		always_ff @(posedge clk) begin
			quo_s[k+1] <= {cur_quo[QW-2:0], take};
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= take ? DW'(part - {1'b0, cur_dvs}) : DW'(part);
				dvs_s[k+1] <= cur_dvs;
				low_s[k+1] <= cur_low << 1;
			end
		end
	end

	assign quotient = quo_s[QW];

endmodule

// ----- rtl/two_link_joint_solver.sv -----
// throughput: one beat per clock once busy has dropped after reset, set by the fully pipelined root and divider units
// (two 27-stage square roots, five 28-stage dividers, one bit per stage)
// reset: valid line cleared, both link lengths back to 50, busy high until the first clock
// results cannot be held off by the receiver
module two_link_joint_solver (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tljs_pkg::in_t         item,
	output logic                  done,
	output tljs_pkg::out_t        result,
	input  logic                  cfg_we,
	input  tljs_pkg::cfg_reg_t    cfg_index,
	input  logic [tljs_pkg::LW-1:0] cfg_data
);

	localparam int CW  = tljs_pkg::CW;
	localparam int LW  = tljs_pkg::LW;
	localparam int FB  = tljs_pkg::FB;
	localparam int AW  = tljs_pkg::AW;
	localparam int SW  = tljs_pkg::SW;
	localparam int IW  = tljs_pkg::IW;
	localparam int LAT = tljs_pkg::LATENCY;

	logic                busy_q;
	logic [LW-1:0]       len0_q;
	logic [LW-1:0]       len1_q;
	logic [LAT-1:0]      vld_q;
	logic                accept;

	// stage 1
	logic [CW:0]         dxw;
	logic [CW:0]         dyw;
	logic [CW-1:0]       c0x_s1, c0y_s1;
	logic [AW-1:0]       dxa_s1, dya_s1;
	logic                dxs_s1, dys_s1;
	tljs_pkg::pick_rule_t rule_s1;

	// stage 2
	logic [CW-1:0]       c0x_s2, c0y_s2;
	logic [AW-1:0]       dxa_s2, dya_s2;
	logic                dxs_s2, dys_s2;
	tljs_pkg::pick_rule_t rule_s2;
	logic [2*AW-1:0]     dx2_s2, dy2_s2;
	logic [2*LW-1:0]     r0sq_s2, r1sq_s2;
	logic [2*LW+1:0]     sum2_s2;
	logic [2*LW-1:0]     diff2_s2;
	logic [LW:0]         sum_len;
	logic [LW-1:0]       diff_len;

	// stage 3
	logic [2*AW:0]       d2;
	logic [tljs_pkg::NW:0] nfull;
	tljs_pkg::side_t     side_in;
	logic [tljs_pkg::D2W-1:0] d2_s3;

	tljs_pkg::side_t     side_s [0:tljs_pkg::SIDE_N-1];
	tljs_pkg::side_t     side_dq;
	tljs_pkg::side_t     side_am;

	logic [tljs_pkg::SQ_QW-1:0] root_a;
	logic [tljs_pkg::SQ_QW-1:0] root_h;
	logic [tljs_pkg::DV_QW-1:0] quo_a;
	logic [2*tljs_pkg::DV_QW-1:0] asq_s59;
	logic [tljs_pkg::SQ_RW-1:0] hrad_s60;
	logic [2*tljs_pkg::DV_QW-1:0] tgt;

	logic [tljs_pkg::PW-1:0] pax_s88, pay_s88, phx_s88, phy_s88;
	logic [tljs_pkg::DV_QW-1:0] q_ax, q_ay, q_hx, q_hy;

	logic [SW-1:0]       base_x, base_y, sax, say;
	logic [SW-1:0]       qax_e, qay_e, qhx_e, qhy_e;
	logic [IW-1:0]       mx_s117, my_s117;
	logic [SW-1:0]       ty_s117, tx_s117;

	logic [SW-1:0]       mxf, myf;
	logic signed [CW-1:0] x1_s118, y1_s118, x2_s118, y2_s118;
	logic                pick_first;
	tljs_pkg::side_t     side_last;
	tljs_pkg::out_t      result_s119;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = vld_q[LAT-1];
	assign result = result_s119;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			len0_q <= tljs_pkg::LEN_RESET;
			len1_q <= tljs_pkg::LEN_RESET;
			vld_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[LAT-2:0], accept};
			if (cfg_we) begin
				case (cfg_index)
					tljs_pkg::CFG_FIRST_LEN:  len0_q <= cfg_data;
					tljs_pkg::CFG_SECOND_LEN: len1_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// deltas and their magnitudes
	assign dxw = {item.second_center_x[CW-1], item.second_center_x}
		- {item.first_center_x[CW-1], item.first_center_x};
	assign dyw = {item.second_center_y[CW-1], item.second_center_y}
		- {item.first_center_y[CW-1], item.first_center_y};

	always_ff @(posedge clk) begin
		c0x_s1  <= item.first_center_x;
		c0y_s1  <= item.first_center_y;
		dxs_s1  <= dxw[CW];
		dys_s1  <= dyw[CW];
		dxa_s1  <= dxw[CW] ? AW'(~dxw + (CW+1)'(1)) : AW'(dxw);
		dya_s1  <= dyw[CW] ? AW'(~dyw + (CW+1)'(1)) : AW'(dyw);
		rule_s1 <= item.pick_rule;
	end

	assign sum_len  = {1'b0, len0_q} + {1'b0, len1_q};
	assign diff_len = (len0_q > len1_q) ? (len0_q - len1_q) : (len1_q - len0_q);

	always_ff @(posedge clk) begin
		c0x_s2   <= c0x_s1;
		c0y_s2   <= c0y_s1;
		dxa_s2   <= dxa_s1;
		dya_s2   <= dya_s1;
		dxs_s2   <= dxs_s1;
		dys_s2   <= dys_s1;
		rule_s2  <= rule_s1;
		dx2_s2   <= dxa_s1 * dxa_s1;
		dy2_s2   <= dya_s1 * dya_s1;
		r0sq_s2  <= len0_q * len0_q;
		r1sq_s2  <= len1_q * len1_q;
		sum2_s2  <= sum_len * sum_len;
		diff2_s2 <= diff_len * diff_len;
	end

	// squared distance, range test, a numerator
	assign d2    = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign nfull = (tljs_pkg::NW+1)'(r0sq_s2) - (tljs_pkg::NW+1)'(r1sq_s2)
		+ (tljs_pkg::NW+1)'(d2[tljs_pkg::D2W-1:0]);

	always_comb begin
		side_in.found = (d2 != '0) && (d2 <= (2*AW+1)'(sum2_s2))
			&& (d2 >= (2*AW+1)'(diff2_s2));
		side_in.c0x   = c0x_s2;
		side_in.c0y   = c0y_s2;
		side_in.dxa   = dxa_s2[tljs_pkg::DXW-1:0];
		side_in.dya   = dya_s2[tljs_pkg::DXW-1:0];
		side_in.dxs   = dxs_s2;
		side_in.dys   = dys_s2;
		side_in.rule  = rule_s2;
		side_in.nneg  = nfull[tljs_pkg::NW];
		side_in.nabs  = nfull[tljs_pkg::NW]
			? tljs_pkg::NW'(~nfull + (tljs_pkg::NW+1)'(1)) : tljs_pkg::NW'(nfull);
		side_in.r0sq  = r0sq_s2;
		side_in.dq    = '0;
		side_in.amag  = '0;
	end

	always_ff @(posedge clk) begin
		d2_s3 <= d2[tljs_pkg::D2W-1:0];
	end

	always_comb begin
		side_dq      = side_s[tljs_pkg::SQA];
		side_dq.dq   = root_a;
		side_am      = side_s[tljs_pkg::DVA];
		side_am.amag = quo_a;
	end

	// side data follows the item down the pipe, picking up d and a on the way
	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 0; k < tljs_pkg::SIDE_N - 1; k++) begin
			if (k == tljs_pkg::SQA) side_s[k+1] <= side_dq;
			else if (k == tljs_pkg::DVA) side_s[k+1] <= side_am;
			else side_s[k+1] <= side_s[k];
		end
	end

	// d with 16 fraction bits
	tljs_sqrt u_sqrt_d (
		.clk  (clk),
		.rad  ({d2_s3, (2*FB)'(0)}),
		.root (root_a)
	);

	// a = n / (2d)
	tljs_div u_div_a (
		.clk      (clk),
		.dividend ({1'b0, side_s[tljs_pkg::SQA].nabs, (2*FB)'(0)}),
		.divisor  ({root_a, 1'b0}),
		.quotient (quo_a)
	);

	assign tgt = {(2*tljs_pkg::DV_QW-2*LW-2*FB)'(0), side_s[tljs_pkg::DVA+1].r0sq, (2*FB)'(0)};

	always_ff @(posedge clk) begin
		asq_s59  <= quo_a * quo_a;
		hrad_s60 <= (asq_s59 >= tgt) ? '0 : tljs_pkg::SQ_RW'(tgt - asq_s59);
	end

	// h with 16 fraction bits
	tljs_sqrt u_sqrt_h (
		.clk  (clk),
		.rad  (hrad_s60),
		.root (root_h)
	);

	always_ff @(posedge clk) begin
		pax_s88 <= side_s[tljs_pkg::SQH].amag * side_s[tljs_pkg::SQH].dxa;
		pay_s88 <= side_s[tljs_pkg::SQH].amag * side_s[tljs_pkg::SQH].dya;
		phx_s88 <= root_h * side_s[tljs_pkg::SQH].dxa;
		phy_s88 <= root_h * side_s[tljs_pkg::SQH].dya;
	end

	tljs_div u_div_ax (
		.clk      (clk),
		.dividend ({1'b0, pax_s88, FB'(0)}),
		.divisor  ({1'b0, side_s[tljs_pkg::SQH+1].dq}),
		.quotient (q_ax)
	);

	tljs_div u_div_ay (
		.clk      (clk),
		.dividend ({1'b0, pay_s88, FB'(0)}),
		.divisor  ({1'b0, side_s[tljs_pkg::SQH+1].dq}),
		.quotient (q_ay)
	);

	tljs_div u_div_hx (
		.clk      (clk),
		.dividend ({1'b0, phx_s88, FB'(0)}),
		.divisor  ({1'b0, side_s[tljs_pkg::SQH+1].dq}),
		.quotient (q_hx)
	);

	tljs_div u_div_hy (
		.clk      (clk),
		.dividend ({1'b0, phy_s88, FB'(0)}),
		.divisor  ({1'b0, side_s[tljs_pkg::SQH+1].dq}),
		.quotient (q_hy)
	);

	// midpoint, truncated before the h offsets go on
	always_comb begin
		qax_e  = SW'(q_ax);
		qay_e  = SW'(q_ay);
		qhx_e  = SW'(q_hx);
		qhy_e  = SW'(q_hy);
		base_x = {{(SW-CW-FB){side_s[tljs_pkg::DVO].c0x[CW-1]}},
			side_s[tljs_pkg::DVO].c0x, FB'(0)};
		base_y = {{(SW-CW-FB){side_s[tljs_pkg::DVO].c0y[CW-1]}},
			side_s[tljs_pkg::DVO].c0y, FB'(0)};
		sax = (side_s[tljs_pkg::DVO].nneg ^ side_s[tljs_pkg::DVO].dxs)
			? (~qax_e + SW'(1)) : qax_e;
		say = (side_s[tljs_pkg::DVO].nneg ^ side_s[tljs_pkg::DVO].dys)
			? (~qay_e + SW'(1)) : qay_e;
	end

	always_ff @(posedge clk) begin
		mx_s117 <= tljs_pkg::trunc_int(base_x + sax);
		my_s117 <= tljs_pkg::trunc_int(base_y + say);
		ty_s117 <= side_s[tljs_pkg::DVO].dys ? (~qhy_e + SW'(1)) : qhy_e;
		tx_s117 <= side_s[tljs_pkg::DVO].dxs ? (~qhx_e + SW'(1)) : qhx_e;
	end

	assign mxf = {mx_s117, FB'(0)};
	assign myf = {my_s117, FB'(0)};

	always_ff @(posedge clk) begin
		x1_s118 <= CW'(tljs_pkg::trunc_int(mxf + ty_s117));
		y1_s118 <= CW'(tljs_pkg::trunc_int(myf - tx_s117));
		x2_s118 <= CW'(tljs_pkg::trunc_int(mxf - ty_s117));
		y2_s118 <= CW'(tljs_pkg::trunc_int(myf + tx_s117));
	end

	assign side_last = side_s[tljs_pkg::PTS];

	always_comb begin
		case (side_last.rule)
			tljs_pkg::PICK_MINX_MINY:
				pick_first = (x1_s118 != x2_s118) ? (x1_s118 < x2_s118) : (y1_s118 < y2_s118);
			tljs_pkg::PICK_MINY_MAXX:
				pick_first = (y1_s118 != y2_s118) ? (y1_s118 < y2_s118) : !(x1_s118 < x2_s118);
			tljs_pkg::PICK_MINX_MAXY:
				pick_first = (x1_s118 != x2_s118) ? (x1_s118 < x2_s118) : (y1_s118 > y2_s118);
			tljs_pkg::PICK_MAXX_MAXY:
				pick_first = (x1_s118 != x2_s118) ? (x1_s118 > x2_s118) : (y1_s118 > y2_s118);
			default:
				pick_first = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (side_last.found) begin
			result_s119.found          <= 1'b1;
			result_s119.first_point_x  <= x1_s118;
			result_s119.first_point_y  <= y1_s118;
			result_s119.second_point_x <= x2_s118;
			result_s119.second_point_y <= y2_s118;
			result_s119.chosen_x       <= pick_first ? x1_s118 : x2_s118;
			result_s119.chosen_y       <= pick_first ? y1_s118 : y2_s118;
		end else begin
			result_s119 <= '0;
		end
	end

`ifndef ASSERT_OFF
	a_beat_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(tljs_pkg::LATENCY) done)
		else $error("accepted beat did not come out after the pipeline latency");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.first_point_x == '0 && result.first_point_y == '0
			&& result.second_point_x == '0 && result.second_point_y == '0
			&& result.chosen_x == '0 && result.chosen_y == '0)
		else $error("no-solution result carries nonzero points");

	a_chosen_is_point: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.found |->
			(result.chosen_x == result.first_point_x && result.chosen_y == result.first_point_y)
			|| (result.chosen_x == result.second_point_x
				&& result.chosen_y == result.second_point_y))
		else $error("chosen joint is neither intersection point");
`endif

endmodule

// ----- tb/two_link_joint_solver_test.sv -----
`timescale 1ns / 100ps

module two_link_joint_solver_test;

	localparam int SETTLE = tljs_pkg::LATENCY + 20;
	localparam int STALL_LIMIT = 4000;
	localparam int LW = tljs_pkg::LW;
	localparam int CW = tljs_pkg::CW;
	localparam int FB = tljs_pkg::FB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	tljs_pkg::in_t item = '0;
	logic done;
	tljs_pkg::out_t result;
	logic cfg_we = 1'b0;
	tljs_pkg::cfg_reg_t cfg_index = tljs_pkg::CFG_FIRST_LEN;
	logic [LW-1:0] cfg_data = '0;

	two_link_joint_solver u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tljs_pkg::in_t pending_beats[$];
	tljs_pkg::out_t expected_joints[$];
	logic [LW-1:0] len0 = tljs_pkg::LEN_RESET, len1 = tljs_pkg::LEN_RESET;
	int gap = 0;
	bit no_gaps = 0;
	int fails = 0;
	int stall = 0;

	function automatic bit [63:0] isqrt(bit [127:0] n);
		bit [63:0] r, t;
		r = 0;
		for (int b = 40; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= n) r = t;
		end
		return r;
	endfunction

	function automatic bit [63:0] frac_div(bit [63:0] x, bit [63:0] y);
		bit [63:0] q, rm;
		q = x / y;
		rm = x % y;
		return (q << FB) + ((rm << FB) / y);
	endfunction

	function automatic longint scale_by(longint m, longint delta, bit [63:0] dq);
		bit neg;
		bit [63:0] um, ud, mag;
		neg = (m < 0) != (delta < 0);
		um = m < 0 ? -m : m;
		ud = delta < 0 ? -delta : delta;
		mag = frac_div(um * ud, dq);
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint to_int(longint s);
		bit [63:0] u;
		if (s < 0) begin
			u = -s;
			return -longint'(u >> FB);
		end
		u = s;
		return longint'(u >> FB);
	endfunction

	function automatic tljs_pkg::out_t solve_joint(tljs_pkg::in_t it, logic [LW-1:0] l0,
		logic [LW-1:0] l1);
		tljs_pkg::out_t o;
		longint c0x, c0y, dx, dy, d2, r0, r1, sum, diff, n, aq, hq, mx, my, tx, ty;
		bit [63:0] dq, amag;
		bit [127:0] tgt, asq;
		logic signed [CW-1:0] p0, p1, p2, p3;
		bit first;
		o = '0;
		c0x = it.first_center_x;
		c0y = it.first_center_y;
		dx = longint'(it.second_center_x) - c0x;
		dy = longint'(it.second_center_y) - c0y;
		d2 = dx * dx + dy * dy;
		r0 = l0;
		r1 = l1;
		sum = r0 + r1;
		diff = r0 > r1 ? r0 - r1 : r1 - r0;
		if (d2 == 0 || d2 > sum * sum || d2 < diff * diff) return o;
		dq = isqrt(128'(d2) << (2 * FB));
		n = r0 * r0 - r1 * r1 + d2;
		amag = frac_div(64'(n < 0 ? -n : n) << FB, 2 * dq);
		aq = n < 0 ? -longint'(amag) : longint'(amag);
		tgt = 128'(r0 * r0) << (2 * FB);
		asq = 128'(amag) * 128'(amag);
		hq = (asq >= tgt) ? 0 : longint'(isqrt(tgt - asq));
		mx = to_int(c0x * 65536 + scale_by(aq, dx, dq));
		my = to_int(c0y * 65536 + scale_by(aq, dy, dq));
		ty = scale_by(hq, dy, dq);
		tx = scale_by(hq, dx, dq);
		p0 = CW'(to_int(mx * 65536 + ty));
		p1 = CW'(to_int(my * 65536 - tx));
		p2 = CW'(to_int(mx * 65536 - ty));
		p3 = CW'(to_int(my * 65536 + tx));
		case (it.pick_rule)
			tljs_pkg::PICK_MINX_MINY: first = (p0 != p2) ? (p0 < p2) : (p1 < p3);
			tljs_pkg::PICK_MINY_MAXX: first = (p1 != p3) ? (p1 < p3) : !(p0 < p2);
			tljs_pkg::PICK_MINX_MAXY: first = (p0 != p2) ? (p0 < p2) : (p1 > p3);
			default:                  first = (p0 != p2) ? (p0 > p2) : (p1 > p3);
		endcase
		o.found = 1'b1;
		o.first_point_x = p0;
		o.first_point_y = p1;
		o.second_point_x = p2;
		o.second_point_y = p3;
		o.chosen_x = first ? p0 : p2;
		o.chosen_y = first ? p1 : p3;
		return o;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 19);
		if (no_gaps || k < 13) return 0;
		if (k < 19) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	always @(posedge clk) begin
		bit acc;
		acc = start && !busy;
		if (acc) begin
			expected_joints.push_back(solve_joint(item, len0, len1));
			void'(pending_beats.pop_front());
			gap = pick_gap();
		end
		if (start && !acc) begin
		end else if (gap > 0) begin
			gap--;
			start <= 1'b0;
		end else if (pending_beats.size() > 0) begin
			start <= 1'b1;
			item <= pending_beats[0];
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		tljs_pkg::out_t e;
		if (done) begin
			if (expected_joints.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual %h", $time, result);
				fails++;
			end else begin
				e = expected_joints.pop_front();
				if (result !== e) begin
					$display("%0t mismatch: expected %h, actual %h", $time, e, result);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (pending_beats.size() == 0 && expected_joints.size() == 0))
			stall <= 0;
		else
			stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic tljs_pkg::in_t mk(int ax, int ay, int bx, int by, int r);
		tljs_pkg::in_t t;
		t.first_center_x = CW'(ax);
		t.first_center_y = CW'(ay);
		t.second_center_x = CW'(bx);
		t.second_center_y = CW'(by);
		t.pick_rule = tljs_pkg::pick_rule_t'(r);
		return t;
	endfunction

	task automatic drain();
		while (pending_beats.size() > 0 || start || expected_joints.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_lengths(int a, int b);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= tljs_pkg::CFG_FIRST_LEN;
		cfg_data <= LW'(a);
		len0 = LW'(a);
		@(posedge clk);
		cfg_index <= tljs_pkg::CFG_SECOND_LEN;
		cfg_data <= LW'(b);
		len1 = LW'(b);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int cnt);
		int ax, ay, s;
		tljs_pkg::in_t t;
		no_gaps = ($urandom_range(0, 3) == 0);
		s = len0 + len1 + 2;
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				t = tljs_pkg::in_t'({$urandom, $urandom, 2'($urandom)});
			end else begin
				if ($urandom_range(0, 5) == 0)
					ax = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 200) :
						-32768 + $urandom_range(0, 200);
				else
					ax = int'($urandom_range(0, 65535)) - 32768;
				ay = int'($urandom_range(0, 65535)) - 32768;
				t = mk(ax, ay, ax + int'($urandom_range(0, 2 * s)) - s,
					ay + int'($urandom_range(0, 2 * s)) - s, $urandom_range(0, 3));
			end
			pending_beats.push_back(t);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < 4; r++) begin
			pending_beats.push_back(mk(10, 20, 10, 20, r));
			pending_beats.push_back(mk(0, 0, 60, 30, r));
			pending_beats.push_back(mk(5, 5, 5, 65, r));
			pending_beats.push_back(mk(0, 0, 100, 0, r));
		end
		pending_beats.push_back(mk(0, 0, 101, 0, 0));
		pending_beats.push_back(mk(-32768, -32768, 32767, 32767, 1));
		pending_beats.push_back(mk(32767, 32767, 32727, 32767, 2));
		pending_beats.push_back(mk(-32768, 0, -32700, 40, 3));
		pending_beats.push_back(mk(32767, -32768, 32767, -32688, 0));
		random_phase(200);
		set_lengths(0, 0);
		pending_beats.push_back(mk(3, 3, 3, 3, 0));
		pending_beats.push_back(mk(3, 3, 4, 3, 0));
		random_phase(50);
		set_lengths(1023, 1023);
		pending_beats.push_back(mk(0, 0, 2046, 0, 1));
		pending_beats.push_back(mk(32767, 32767, 31767, 32000, 3));
		random_phase(300);
		set_lengths(1023, 0);
		pending_beats.push_back(mk(0, 0, 1023, 0, 2));
		pending_beats.push_back(mk(0, 0, 10, 0, 2));
		random_phase(250);
		set_lengths(40, 300);
		pending_beats.push_back(mk(0, 0, 100, 0, 0));
		random_phase(250);
		for (int k = 0; k < 3; k++) begin
			set_lengths($urandom_range(0, 1023), $urandom_range(0, 1023));
			random_phase(150);
		end
		drain();
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- two_link_joint_solver.f -----
rtl/tljs_pkg.sv
rtl/tljs_sqrt.sv
rtl/tljs_div.sv
rtl/two_link_joint_solver.sv
tb/two_link_joint_solver_test.sv
